### hdl/crast_pkg.sv
// ----------------------------------------------------------------------------
// crast_pkg
// shared constants and codes for the circle rasterizer
// ----------------------------------------------------------------------------
package crast_pkg;

   localparam int RADIUS_BITS_DEFAULT = 11;
   localparam int RADIUS_W            = 11;
   localparam int CENTER_W            = 10;
   localparam int PIX_W               = 13;
   localparam int DEC_W               = 16;
   localparam int QUEUE_DEPTH         = 2;
   localparam int POINTS_PER_STEP     = 8;
   localparam int POINT_IDX_W         = $clog2(POINTS_PER_STEP);

   localparam logic [CENTER_W-1:0] CENTER_X_RESET = CENTER_W'(320);
   localparam logic [CENTER_W-1:0] CENTER_Y_RESET = CENTER_W'(240);

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y = 1'b1;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

endpackage

### hdl/crast_queue.sv
// ----------------------------------------------------------------------------
// crast_queue
// small job queue between the step front end and the pixel back end
// ----------------------------------------------------------------------------
module crast_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = crast_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/crast_front.sv
// ----------------------------------------------------------------------------
// crast_front
// accepts start and step transactions, keeps the midpoint state, issues jobs
// ----------------------------------------------------------------------------
module crast_front #(
   parameter int RADIUS_BITS = crast_pkg::RADIUS_BITS_DEFAULT,
   parameter int JOB_W       = 2 * RADIUS_BITS + 2 * crast_pkg::CENTER_W + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [crast_pkg::RADIUS_W-1:0]     req_radius,
   input  logic [crast_pkg::CENTER_W-1:0]     center_x,
   input  logic [crast_pkg::CENTER_W-1:0]     center_y,
   input  logic                               queue_full,
   output logic                               job_push,
   output logic [JOB_W-1:0]                   job_data
);

   localparam int DW = crast_pkg::DEC_W;

   logic [RADIUS_BITS-1:0] x_ff, x_in;
   logic [RADIUS_BITS-1:0] y_ff, y_in;
   logic [DW-1:0]          dec_ff, dec_in;
   logic                   active_ff, active_in;

   logic                   accept;
   logic                   finished;
   logic                   end_now;
   logic                   job_done;
   logic [RADIUS_BITS-1:0] radius;
   logic [DW-1:0]          x_ext, y_ext;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign radius    = RADIUS_BITS'(req_radius);
   assign x_ext     = DW'(x_ff);
   assign y_ext     = DW'(y_ff);
   assign finished  = !active_ff || (x_ff > y_ff);

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      active_in = active_ff;
      job_push  = 1'b0;
      job_done  = 1'b0;
      end_now   = 1'b0;
      if (accept) begin
         case (req_func)
            crast_pkg::FUNC_START: begin
               x_in      = '0;
               y_in      = radius;
               dec_in    = DW'(3) - (DW'(radius) << 1);
               active_in = 1'b1;
            end
            crast_pkg::FUNC_STEP: begin
               job_push = 1'b1;
               if (finished) begin
                  job_done  = 1'b1;
                  active_in = 1'b0;
               end else begin
                  if (dec_ff[DW-1] || (dec_ff == '0)) begin
                     dec_in = dec_ff + (x_ext << 2) + DW'(6);
                  end else begin
                     dec_in = dec_ff + ((x_ext - y_ext) << 2) + DW'(10);
                     if (y_ff == '0) begin
                        end_now = 1'b1;
                     end else begin
                        y_in = y_ff - 1'b1;
                     end
                  end
                  if (x_ff == '1) begin
                     end_now = 1'b1;
                  end else begin
                     x_in = x_ff + 1'b1;
                  end
                  if (end_now) begin
                     x_in = RADIUS_BITS'(1);
                     y_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign job_data = {job_done, center_y, center_x, y_ff, x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         y_ff      <= '0;
         dec_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         dec_ff    <= dec_in;
         active_ff <= active_in;
      end
   end

endmodule

### hdl/crast_back.sv
// ----------------------------------------------------------------------------
// crast_back
// expands jobs into octant pixels in an output register, one per unstalled cycle
// ----------------------------------------------------------------------------
module crast_back #(
   parameter int RADIUS_BITS = crast_pkg::RADIUS_BITS_DEFAULT,
   parameter int JOB_W       = 2 * RADIUS_BITS + 2 * crast_pkg::CENTER_W + 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   input  logic [JOB_W-1:0]                      job_data,
   output logic                                  job_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [crast_pkg::PIX_W-1:0]    rsp_pixel_x,
   output logic signed [crast_pkg::PIX_W-1:0]    rsp_pixel_y,
   output logic                                  rsp_done_res,
   output logic                                  rsp_last
);

   localparam int PW = crast_pkg::PIX_W;
   localparam int CW = crast_pkg::CENTER_W;
   localparam int IW = crast_pkg::POINT_IDX_W;

   logic [IW-1:0]          idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   logic [PW-1:0]          px_ff, px_in;
   logic [PW-1:0]          py_ff, py_in;
   logic                   done_ff, done_in;
   logic                   last_ff, last_in;

   logic [RADIUS_BITS-1:0] jx, jy;
   logic [CW-1:0]          jcx, jcy;
   logic                   jdone;
   logic                   load;
   logic                   final_point;
   logic [PW-1:0]          a, b, cx, cy;

   assign jx    = job_data[RADIUS_BITS-1:0];
   assign jy    = job_data[2*RADIUS_BITS-1:RADIUS_BITS];
   assign jcx   = job_data[2*RADIUS_BITS+CW-1:2*RADIUS_BITS];
   assign jcy   = job_data[2*RADIUS_BITS+2*CW-1:2*RADIUS_BITS+CW];
   assign jdone = job_data[JOB_W-1];

   assign cx          = PW'(jcx);
   assign cy          = PW'(jcy);
   assign load        = job_valid && (!valid_ff || rsp_ready);
   assign final_point = jdone || (idx_ff == IW'(crast_pkg::POINTS_PER_STEP - 1));
   assign job_pop     = load && final_point;

   // point order: (+x,-y) (-x,+y) (-x,-y) (+x,+y) (+y,+x) (+y,-x) (-y,+x) (-y,-x)
   always_comb begin
      a = PW'(jx);
      b = PW'(jy);
      if (idx_ff[IW-1]) begin
         a = PW'(jy);
         b = PW'(jx);
      end
      case (idx_ff)
         3'd0:    begin px_in = cx + a; py_in = cy - b; end
         3'd1:    begin px_in = cx - a; py_in = cy + b; end
         3'd2:    begin px_in = cx - a; py_in = cy - b; end
         3'd3:    begin px_in = cx + a; py_in = cy + b; end
         3'd4:    begin px_in = cx + a; py_in = cy + b; end
         3'd5:    begin px_in = cx + a; py_in = cy - b; end
         3'd6:    begin px_in = cx - a; py_in = cy + b; end
         default: begin px_in = cx - a; py_in = cy - b; end
      endcase
      if (jdone) begin
         px_in = '0;
         py_in = '0;
      end
      done_in = jdone;
      last_in = final_point;
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_point ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         done_ff <= done_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_pixel_x  = px_ff;
   assign rsp_pixel_y  = py_ff;
   assign rsp_done_res = done_ff;
   assign rsp_last     = last_ff;

endmodule

### hdl/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_rasterizer
// midpoint circle rasterizer: start loads a radius, a step emits a done result or 8 pixels
// ----------------------------------------------------------------------------
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------------
//  req     | req_valid/ready, req_func, req_radius   | start or step transaction
//  rsp     | rsp_valid/ready, pixel_x/y, done, last  | one pixel or done marker
//  csr     | csr_we, csr_index, csr_data             | circle center x / y
//
//  a start is taken in the front end and gives no result
//  a step gives 8 results from the back-end pixel counter, one per cycle unless
//  rsp_ready stalls; a step on a finished or unstarted circle gives one done result
//  a two-job queue lets the front accept while the back end drains
//  synchronous active-high reset; the output register holds while rsp_ready is low
// ----------------------------------------------------------------------------
module circle_rasterizer #(
   parameter int RADIUS_BITS = crast_pkg::RADIUS_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [crast_pkg::RADIUS_W-1:0]        req_radius,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [crast_pkg::PIX_W-1:0]    rsp_pixel_x,
   output logic signed [crast_pkg::PIX_W-1:0]    rsp_pixel_y,
   output logic                                  rsp_done_res,
   output logic                                  rsp_last,
   input  logic                                  csr_we,
   input  logic [crast_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [crast_pkg::CENTER_W-1:0]        csr_data
);

   localparam int JOB_W = 2 * RADIUS_BITS + 2 * crast_pkg::CENTER_W + 1;

   logic [crast_pkg::CENTER_W-1:0] center_x_ff, center_x_in;
   logic [crast_pkg::CENTER_W-1:0] center_y_ff, center_y_in;

   logic             queue_full;
   logic             job_push;
   logic [JOB_W-1:0] job_in_data;
   logic             job_pop;
   logic [JOB_W-1:0] job_head;
   logic             job_valid;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_we) begin
         case (csr_index)
            crast_pkg::CSR_CENTER_X: center_x_in = csr_data;
            crast_pkg::CSR_CENTER_Y: center_y_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= crast_pkg::CENTER_X_RESET;
         center_y_ff <= crast_pkg::CENTER_Y_RESET;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   crast_front #(
      .RADIUS_BITS (RADIUS_BITS),
      .JOB_W       (JOB_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_radius (req_radius),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (job_in_data)
   );

   crast_queue #(
      .DATA_W (JOB_W),
      .DEPTH  (crast_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (queue_full),
      .pop       (job_pop),
      .head_data (job_head),
      .not_empty (job_valid)
   );

   crast_back #(
      .RADIUS_BITS (RADIUS_BITS),
      .JOB_W       (JOB_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_data     (job_head),
      .job_pop      (job_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_done_res (rsp_done_res),
      .rsp_last     (rsp_last)
   );

endmodule

### tb/circle_rasterizer_test.sv
// ----------------------------------------------------------------------------
// circle_rasterizer_test
// drives start and step transactions into the circle rasterizer while a
// cycle-free predictor tracks x, y and the decision value, and every pixel or
// done result is checked field by field against the predicted stream; the
// circle center is moved between phases, including all four corners
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_rasterizer_test;

   localparam int LIMIT_NS = 400_000 * 12;

   typedef struct packed {
      logic [crast_pkg::PIX_W-1:0] px;
      logic [crast_pkg::PIX_W-1:0] py;
      logic                        done;
      logic                        last;
   } pixel_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic                                 req_func;
   logic [crast_pkg::RADIUS_W-1:0]       req_radius;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [crast_pkg::PIX_W-1:0]   rsp_pixel_x;
   logic signed [crast_pkg::PIX_W-1:0]   rsp_pixel_y;
   logic                                 rsp_done_res;
   logic                                 rsp_last;
   logic                                 csr_we;
   logic [crast_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [crast_pkg::CENTER_W-1:0]       csr_data;

   // predictor state
   logic [crast_pkg::CENTER_W-1:0] center_x_cfg;
   logic [crast_pkg::CENTER_W-1:0] center_y_cfg;
   logic [crast_pkg::RADIUS_W-1:0] pos_x;
   logic [crast_pkg::RADIUS_W-1:0] pos_y;
   logic [crast_pkg::DEC_W-1:0]    decision_q;
   logic                           circle_active;
   logic                           circle_finished;

   pixel_type pixel_expect_q[$];
   int        mismatch_count;
   int        items_sent;
   logic      steady;

   circle_rasterizer DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_radius   (req_radius),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_done_res (rsp_done_res),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("[circle_rasterizer] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void push_pixel(input int px, input int py, input logic lst);
      pixel_type p;
      p.px = crast_pkg::PIX_W'(px);
      p.py = crast_pkg::PIX_W'(py);
      p.done = 1'b0;
      p.last = lst;
      pixel_expect_q.push_back(p);
   endfunction

   function automatic void predict_circle_op(input logic func,
                                             input logic [crast_pkg::RADIUS_W-1:0] radius);
      int        cx;
      int        cy;
      int        x;
      int        y;
      int        d;
      logic      end_now;
      pixel_type done_pix;
      if (func == crast_pkg::FUNC_START) begin
         pos_x = '0;
         pos_y = radius;
         decision_q = crast_pkg::DEC_W'(3 - 2 * int'(radius));
         circle_active = 1'b1;
         circle_finished = 1'b0;
         return;
      end
      if (!circle_active || pos_x > pos_y) begin
         circle_active = 1'b0;
         circle_finished = 1'b1;
         done_pix = '{px: '0, py: '0, done: 1'b1, last: 1'b1};
         pixel_expect_q.push_back(done_pix);
         return;
      end
      cx = int'(center_x_cfg);
      cy = int'(center_y_cfg);
      x = int'(pos_x);
      y = int'(pos_y);
      push_pixel(cx + x, cy - y, 1'b0);
      push_pixel(cx - x, cy + y, 1'b0);
      push_pixel(cx - x, cy - y, 1'b0);
      push_pixel(cx + x, cy + y, 1'b0);
      push_pixel(cx + y, cy + x, 1'b0);
      push_pixel(cx + y, cy - x, 1'b0);
      push_pixel(cx - y, cy + x, 1'b0);
      push_pixel(cx - y, cy - x, 1'b1);
      d = int'($signed(decision_q));
      end_now = 1'b0;
      if (d <= 0) begin
         decision_q = crast_pkg::DEC_W'(d + 4 * x + 6);
      end else begin
         decision_q = crast_pkg::DEC_W'(d + 4 * (x - y) + 10);
         if (pos_y == '0) begin
            end_now = 1'b1;
         end else begin
            pos_y = pos_y - 1'b1;
         end
      end
      if (pos_x == '1) begin
         end_now = 1'b1;
      end else begin
         pos_x = pos_x + 1'b1;
      end
      // force the next step onto the done result
      if (end_now) begin
         pos_x = crast_pkg::RADIUS_W'(1);
         pos_y = '0;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{px: rsp_pixel_x, py: rsp_pixel_y, done: rsp_done_res, last: rsp_last};
         if (pixel_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction x=%0d y=%0d done=%b last=%b",
                                      $signed(got.px), $signed(got.py), got.done, got.last));
         end else begin
            want = pixel_expect_q.pop_front();
            if (got.px !== want.px)
               report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                         $signed(got.px), $signed(want.px)));
            if (got.py !== want.py)
               report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                         $signed(got.py), $signed(want.py)));
            if (got.done !== want.done)
               report_mismatch($sformatf("done_res %b, expected %b", got.done, want.done));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 32);
   end

   task automatic send_op(input logic func, input logic [crast_pkg::RADIUS_W-1:0] radius);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 32) gap = $urandom_range(1, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_radius <= radius;
      do @(posedge clock); while (!req_ready);
      predict_circle_op(func, radius);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_expect_q.size() != 0) @(posedge clock);
      // a start in flight gives no result
      repeat (12) @(posedge clock);
   endtask

   task automatic write_center(input logic [crast_pkg::CSR_INDEX_W-1:0] idx,
                               input logic [crast_pkg::CENTER_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         crast_pkg::CSR_CENTER_X: center_x_cfg = val;
         crast_pkg::CSR_CENTER_Y: center_y_cfg = val;
         default: ;
      endcase
   endtask

   task automatic set_centers(input logic [crast_pkg::CENTER_W-1:0] cx,
                              input logic [crast_pkg::CENTER_W-1:0] cy);
      settle();
      write_center(crast_pkg::CSR_CENTER_X, cx);
      write_center(crast_pkg::CSR_CENTER_Y, cy);
   endtask

   task automatic draw_circle(input logic [crast_pkg::RADIUS_W-1:0] radius,
                              input int max_steps);
      int n;
      send_op(crast_pkg::FUNC_START, radius);
      n = 0;
      while (!circle_finished && n < max_steps) begin
         send_op(crast_pkg::FUNC_STEP, crast_pkg::RADIUS_W'($urandom_range(0, 2047)));
         n++;
      end
   endtask

   task automatic random_sequence();
      int pick;
      int r;
      pick = $urandom_range(99);
      r = ($urandom_range(9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 30);
      if (pick < 78) begin
         draw_circle(crast_pkg::RADIUS_W'(r), (r > 64) ? $urandom_range(1, 12) : 4096);
         if ($urandom_range(3) == 0)
            send_op(crast_pkg::FUNC_STEP, crast_pkg::RADIUS_W'($urandom_range(0, 2047)));
      end else if (pick < 90) begin
         // abandoned part way through
         draw_circle(crast_pkg::RADIUS_W'(r), $urandom_range(0, 5));
      end else begin
         send_op(logic'($urandom_range(0, 1)), crast_pkg::RADIUS_W'($urandom_range(0, 2047)));
      end
   endtask

   task automatic run_random_phase(input int n_items, input logic [crast_pkg::CENTER_W-1:0] cx,
                                   input logic [crast_pkg::CENTER_W-1:0] cy);
      int target;
      set_centers(cx, cy);
      target = items_sent + n_items;
      while (items_sent < target) random_sequence();
   endtask

   task automatic test_step_without_circle();
      send_op(crast_pkg::FUNC_STEP, '0);
      send_op(crast_pkg::FUNC_STEP, '1);
   endtask

   task automatic test_zero_radius();
      draw_circle('0, 4);
      send_op(crast_pkg::FUNC_STEP, '1);
   endtask

   task automatic test_small_radii();
      draw_circle(crast_pkg::RADIUS_W'(1), 8);
      draw_circle(crast_pkg::RADIUS_W'(2), 8);
   endtask

   task automatic test_max_radius_restart();
      draw_circle('1, 4);
      draw_circle(crast_pkg::RADIUS_W'(3), 8);
   endtask

   task automatic test_corner_centers();
      run_random_phase(50, '0, '0);
      run_random_phase(50, '1, '1);
      run_random_phase(50, '0, '1);
      run_random_phase(50, '1, '0);
   endtask

   task automatic test_no_idle_stream();
      settle();
      steady = 1'b1;
      run_random_phase(60, crast_pkg::CENTER_W'($urandom_range(0, 1023)),
                       crast_pkg::CENTER_W'($urandom_range(0, 1023)));
      settle();
      steady = 1'b0;
   endtask

   task automatic test_random_centers();
      repeat (3) begin
         run_random_phase(45, crast_pkg::CENTER_W'($urandom_range(0, 1023)),
                          crast_pkg::CENTER_W'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = crast_pkg::FUNC_START;
      req_radius = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = crast_pkg::CSR_CENTER_X;
      csr_data = '0;
      steady = 1'b0;
      mismatch_count = 0;
      items_sent = 0;
      center_x_cfg = crast_pkg::CENTER_X_RESET;
      center_y_cfg = crast_pkg::CENTER_Y_RESET;
      pos_x = '0;
      pos_y = '0;
      decision_q = '0;
      circle_active = 1'b0;
      circle_finished = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_step_without_circle();
      test_zero_radius();
      test_small_radii();
      test_max_radius_restart();
      test_corner_centers();
      test_no_idle_stream();
      test_random_centers();

      settle();
      repeat (20) @(posedge clock);
      if (pixel_expect_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pixel_expect_q.size()));
      if (mismatch_count == 0) begin
         $display("[circle_rasterizer] OK");
      end else begin
         $display("[circle_rasterizer] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/crast_pkg.sv
hdl/crast_queue.sv
hdl/crast_front.sv
hdl/crast_back.sv
hdl/circle_rasterizer.sv
tb/circle_rasterizer_test.sv
